[design/scbp_pkg.sv]
// Shared types, constants and helper functions for the size class buffer pool.
package scbp_pkg;

    localparam int unsigned NUM_CLASSES = 4;
    localparam int unsigned CLS_W       = 2;
    localparam int unsigned ID_W        = 5;
    localparam int unsigned SIZE_W      = 16;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam int unsigned CLASS_COUNT [NUM_CLASSES] = '{16, 8, 4, 2};
    localparam int unsigned POOL_TOTAL =
        CLASS_COUNT[0] + CLASS_COUNT[1] + CLASS_COUNT[2] + CLASS_COUNT[3];

    localparam logic [SIZE_W-1:0] SIZE_RESET [NUM_CLASSES] =
        '{16'd256, 16'd1024, 16'd4096, 16'd16384};

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_BAD_ID    = 2'd3;

    typedef logic [NUM_CLASSES-1:0][SIZE_W-1:0] size_arr_t;

    typedef struct packed {
        logic            pop;
        logic            push;
        logic [CLS_W-1:0] cls;
        logic [ID_W-1:0]  id;
    } list_op_t;

    typedef struct packed {
        logic [NUM_CLASSES-1:0][ID_W-1:0] head;
        logic [NUM_CLASSES-1:0]           head_valid;
    } list_stat_t;

    function automatic int unsigned class_base(input int unsigned c);
        int unsigned b;
        b = 0;
        for (int unsigned k = 0; k < NUM_CLASSES; k++) begin
            if (k < c) begin
                b = b + CLASS_COUNT[k];
            end
        end
        return b;
    endfunction

    function automatic logic is_last(input int unsigned id);
        logic r;
        r = 1'b0;
        for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
            if (id == class_base(c) + CLASS_COUNT[c] - 1) begin
                r = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [CLS_W-1:0] owner_class(input logic [ID_W-1:0] id);
        logic [CLS_W-1:0] r;
        logic             hit;
        r   = CLS_W'(NUM_CLASSES - 1);
        hit = 1'b0;
        for (int unsigned c = 0; c < NUM_CLASSES - 1; c++) begin
            if (!hit && ({26'd0, id} < 31'(class_base(c + 1)))) begin
                r   = CLS_W'(c);
                hit = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [ID_W-1:0] clamp_id(input logic [ID_W-1:0] id);
        return ({26'd0, id} >= 31'(POOL_TOTAL)) ? '0 : id;
    endfunction

endpackage

[design/scbp_lists.sv]
// Free list storage: per-class heads and the next-pointer store.
module scbp_lists (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scbp_pkg::list_op_t   op,
    output scbp_pkg::list_stat_t stat
);

    logic [scbp_pkg::NUM_CLASSES-1:0][scbp_pkg::ID_W-1:0] head_reg;
    logic [scbp_pkg::NUM_CLASSES-1:0]                     hvalid_reg;
    logic [scbp_pkg::ID_W-1:0] next_reg   [scbp_pkg::POOL_TOTAL];
    logic                      nvalid_reg [scbp_pkg::POOL_TOTAL];

    logic [scbp_pkg::ID_W-1:0] pop_id;

    assign pop_id          = scbp_pkg::clamp_id(head_reg[op.cls]);
    assign stat.head       = head_reg;
    assign stat.head_valid = hvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int unsigned c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
                head_reg[c]   <= scbp_pkg::ID_W'(scbp_pkg::class_base(c));
                hvalid_reg[c] <= 1'b1;
            end
            for (int unsigned i = 0; i < scbp_pkg::POOL_TOTAL; i++) begin
                next_reg[i]   <= scbp_pkg::is_last(i) ? '0 : scbp_pkg::ID_W'(i + 1);
                nvalid_reg[i] <= !scbp_pkg::is_last(i);
            end
        end else if (op.pop) begin
            head_reg[op.cls]   <= next_reg[pop_id];
            hvalid_reg[op.cls] <= nvalid_reg[pop_id];
            nvalid_reg[pop_id] <= 1'b0;
        end else if (op.push) begin
            next_reg[op.id]    <= head_reg[op.cls];
            nvalid_reg[op.id]  <= hvalid_reg[op.cls];
            head_reg[op.cls]   <= op.id;
            hvalid_reg[op.cls] <= 1'b1;
        end
    end

endmodule

[design/scbp_ctrl.sv]
// Sequencer with a shared size comparator; owns the result register.
module scbp_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [scbp_pkg::SIZE_W-1:0]   s_req_size,
    input  logic [scbp_pkg::ID_W-1:0]     s_buffer_id,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ok,
    output logic [1:0]                    m_status,
    output logic [scbp_pkg::ID_W-1:0]     m_granted_id,
    output logic [scbp_pkg::CLS_W-1:0]    m_granted_class,
    input  scbp_pkg::size_arr_t           class_size,
    input  scbp_pkg::list_stat_t          stat,
    output scbp_pkg::list_op_t            op
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_FREE = 2'd3;

    localparam logic [scbp_pkg::CLS_W-1:0] LAST_CLS =
        scbp_pkg::CLS_W'(scbp_pkg::NUM_CLASSES - 1);

    logic [1:0]                    state_reg, state_next;
    logic [scbp_pkg::SIZE_W-1:0]   req_reg, req_next;
    logic [scbp_pkg::ID_W-1:0]     bid_reg, bid_next;
    logic [scbp_pkg::CLS_W-1:0]    idx_reg, idx_next;
    logic                          fit_reg, fit_next;

    logic                          ovalid_reg, ovalid_next;
    logic                          ok_reg, ok_next;
    logic [1:0]                    status_reg, status_next;
    logic [scbp_pkg::ID_W-1:0]     gid_reg, gid_next;
    logic [scbp_pkg::CLS_W-1:0]    gcls_reg, gcls_next;

    logic cmp_lt;
    logic fit_now;
    logic out_busy;
    logic finish;

    assign cmp_lt   = req_reg < class_size[idx_reg];
    assign fit_now  = fit_reg | cmp_lt;
    assign out_busy = ovalid_reg && !m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    assign m_valid         = ovalid_reg;
    assign m_ok            = ok_reg;
    assign m_status        = status_reg;
    assign m_granted_id    = gid_reg;
    assign m_granted_class = gcls_reg;

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        bid_next    = bid_reg;
        idx_next    = idx_reg;
        fit_next    = fit_reg;
        ok_next     = ok_reg;
        status_next = status_reg;
        gid_next    = gid_reg;
        gcls_next   = gcls_reg;
        finish      = 1'b0;
        op          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req_size;
                    bid_next   = s_buffer_id;
                    idx_next   = '0;
                    fit_next   = 1'b0;
                    state_next = (s_cmd == scbp_pkg::CMD_FREE) ? S_FREE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (fit_now && stat.head_valid[idx_reg]) begin
                    state_next = S_POP;
                end else if (idx_reg == LAST_CLS) begin
                    if (!out_busy) begin
                        finish      = 1'b1;
                        ok_next     = 1'b0;
                        status_next = fit_now ? scbp_pkg::ST_EXHAUSTED : scbp_pkg::ST_NO_FIT;
                        gid_next    = '0;
                        gcls_next   = '0;
                        state_next  = S_IDLE;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                    fit_next = fit_now;
                end
            end
            S_POP: begin
                op.cls = idx_reg;
                if (!out_busy) begin
                    finish      = 1'b1;
                    op.pop      = 1'b1;
                    ok_next     = 1'b1;
                    status_next = scbp_pkg::ST_OK;
                    gid_next    = scbp_pkg::clamp_id(stat.head[idx_reg]);
                    gcls_next   = idx_reg;
                    state_next  = S_IDLE;
                end
            end
            S_FREE: begin
                op.cls = scbp_pkg::owner_class(bid_reg);
                op.id  = bid_reg;
                if (!out_busy) begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                    if ({26'd0, bid_reg} >= 31'(scbp_pkg::POOL_TOTAL)) begin
                        ok_next     = 1'b0;
                        status_next = scbp_pkg::ST_BAD_ID;
                        gid_next    = '0;
                        gcls_next   = '0;
                    end else begin
                        op.push     = 1'b1;
                        ok_next     = 1'b1;
                        status_next = scbp_pkg::ST_OK;
                        gid_next    = bid_reg;
                        gcls_next   = op.cls;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
        ovalid_next = finish | out_busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        bid_reg    <= bid_next;
        idx_reg    <= idx_next;
        fit_reg    <= fit_next;
        ok_reg     <= ok_next;
        status_reg <= status_next;
        gid_reg    <= gid_next;
        gcls_reg   <= gcls_next;
    end

endmodule

[design/size_class_buffer_pool.sv]
// Top level of the size class buffer pool: config registers and wiring.
//
//  channel  dir  handshake           payload
//  s_       in   s_valid / s_ready   s_cmd, s_req_size, s_buffer_id
//  m_       out  m_valid / m_ready   m_ok, m_status, m_granted_id, m_granted_class
//  cfg_     in   cfg_wr_en           cfg_index, cfg_wr_data
//
// Free: accept, then push. Alloc: accept, then the
// shared size comparator checks one class per cycle, then the pop.
// Synchronous active-low reset restores class sizes and the initial free lists.
// A pending result in the output register lets the next item be accepted;
// the sequencer only stalls when it must write a result over one not yet taken.
module size_class_buffer_pool (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [scbp_pkg::SIZE_W-1:0]     s_req_size,
    input  logic [scbp_pkg::ID_W-1:0]       s_buffer_id,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_ok,
    output logic [1:0]                      m_status,
    output logic [scbp_pkg::ID_W-1:0]       m_granted_id,
    output logic [scbp_pkg::CLS_W-1:0]      m_granted_class,
    input  logic                            cfg_wr_en,
    input  logic [scbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scbp_pkg::SIZE_W-1:0]     cfg_wr_data
);

    scbp_pkg::size_arr_t  size_reg;
    scbp_pkg::list_stat_t stat;
    scbp_pkg::list_op_t   op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int unsigned c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
                size_reg[c] <= scbp_pkg::SIZE_RESET[c];
            end
        end else if (cfg_wr_en) begin
            size_reg[cfg_index] <= cfg_wr_data;
        end
    end

    scbp_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_req_size      (s_req_size),
        .s_buffer_id     (s_buffer_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_status        (m_status),
        .m_granted_id    (m_granted_id),
        .m_granted_class (m_granted_class),
        .class_size      (size_reg),
        .stat            (stat),
        .op              (op)
    );

    scbp_lists u_lists (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .stat    (stat)
    );

endmodule

[sim/pool_grant_checker.sv]
// Checker for the size class buffer pool: watches both channels, predicts each grant, compares.
`timescale 1ns / 1ps
module pool_grant_checker
    import scbp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [SIZE_W-1:0]    s_req_size,
    input  logic [ID_W-1:0]      s_buffer_id,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_ok,
    input  logic [1:0]           m_status,
    input  logic [ID_W-1:0]      m_granted_id,
    input  logic [CLS_W-1:0]     m_granted_class,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_wr_data,
    output int                   errors,
    output int                   pending,
    output int                   checked
);

    typedef struct packed {
        logic             ok;
        logic [1:0]       status;
        logic [ID_W-1:0]  id;
        logic [CLS_W-1:0] cls;
    } grant_t;

    logic [SIZE_W-1:0] csize [NUM_CLASSES];
    logic [ID_W-1:0]   head  [NUM_CLASSES];
    logic              hval  [NUM_CLASSES];
    logic [ID_W-1:0]   link  [POOL_TOTAL];
    logic              lval  [POOL_TOTAL];

    grant_t expected_grants [$];
    int     err_cnt   = 0;
    int     n_checked = 0;

    initial begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    task automatic reset_pool();
        int base;
        base = 0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            csize[c] = SIZE_RESET[c];
            head[c]  = ID_W'(base);
            hval[c]  = 1'b1;
            for (int j = 0; j < CLASS_COUNT[c]; j++) begin
                link[base + j] = (j == CLASS_COUNT[c] - 1) ? '0 : ID_W'(base + j + 1);
                lval[base + j] = (j != CLASS_COUNT[c] - 1);
            end
            base += CLASS_COUNT[c];
        end
    endtask

    function automatic logic [CLS_W-1:0] id_class(input logic [ID_W-1:0] id);
        int               lim;
        logic [CLS_W-1:0] c;
        lim = int'(POOL_TOTAL);
        c   = CLS_W'(NUM_CLASSES - 1);
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if (id < lim) begin
                c = CLS_W'(k);
            end
            lim -= CLASS_COUNT[k];
        end
        return c;
    endfunction

    task automatic apply_pool_op(input logic cmd, input logic [SIZE_W-1:0] req,
                                 input logic [ID_W-1:0] bid, output grant_t g);
        int               start;
        logic             done;
        logic [ID_W-1:0]  id;
        logic [CLS_W-1:0] c;
        g     = '0;
        start = NUM_CLASSES;
        done  = 1'b0;
        if (cmd == CMD_ALLOC) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                if (start == NUM_CLASSES && req < csize[k]) begin
                    start = k;
                end
            end
            if (start == NUM_CLASSES) begin
                g.status = ST_NO_FIT;
            end else begin
                g.status = ST_EXHAUSTED;
                for (int k = start; k < NUM_CLASSES; k++) begin
                    if (!done && hval[k]) begin
                        id = head[k];
                        if (id >= POOL_TOTAL) begin
                            id = '0;
                        end
                        head[k]  = link[id];
                        hval[k]  = lval[id];
                        lval[id] = 1'b0;
                        g.ok     = 1'b1;
                        g.status = ST_OK;
                        g.id     = id;
                        g.cls    = CLS_W'(k);
                        done     = 1'b1;
                    end
                end
            end
        end else if (bid >= POOL_TOTAL) begin
            g.status = ST_BAD_ID;
        end else begin
            c         = id_class(bid);
            link[bid] = head[c];
            lval[bid] = hval[c];
            head[c]   = bid;
            hval[c]   = 1'b1;
            g.ok      = 1'b1;
            g.status  = ST_OK;
            g.id      = bid;
            g.cls     = c;
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin : watch
        grant_t g;
        if (!aresetn) begin
            reset_pool();
            expected_grants.delete();
        end else begin
            // result first: it always belongs to an older item
            if (m_valid && m_ready) begin
                if (expected_grants.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected item, expected none, actual ok %0d status %0d id %0d class %0d",
                             $time, m_ok, m_status, m_granted_id, m_granted_class);
                end else begin
                    g = expected_grants.pop_front();
                    check_field("ok", g.ok, m_ok);
                    check_field("status", g.status, m_status);
                    check_field("granted_id", g.id, m_granted_id);
                    check_field("granted_class", g.cls, m_granted_class);
                    n_checked++;
                end
            end
            if (s_valid && s_ready) begin
                apply_pool_op(s_cmd, s_req_size, s_buffer_id, g);
                expected_grants.push_back(g);
            end
            if (cfg_wr_en) begin
                csize[cfg_index] = cfg_wr_data;
            end
        end
        errors  <= err_cnt;
        pending <= expected_grants.size();
        checked <= n_checked;
    end

endmodule

[sim/tb.sv]
// Testbench top for the size class buffer pool: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
    import scbp_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 235;
    localparam int NUM_PHASES  = 8;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic                 s_cmd       = CMD_ALLOC;
    logic [SIZE_W-1:0]    s_req_size  = '0;
    logic [ID_W-1:0]      s_buffer_id = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic                 m_ok;
    logic [1:0]           m_status;
    logic [ID_W-1:0]      m_granted_id;
    logic [CLS_W-1:0]     m_granted_class;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [SIZE_W-1:0]    cfg_wr_data = '0;

    int errors;
    int pending;
    int checked;

    int tx_gap_max   = 9;
    int rx_gap_max   = 9;
    bit hold_pending = 1'b0;
    int cycles       = 0;

    logic [SIZE_W-1:0] sizes [NUM_CLASSES] = SIZE_RESET;
    logic              cmd_sent [$];
    int                held_ids [$];

    int n_alloc    = 0;
    int n_free     = 0;
    int n_settings = 0;
    int n_nofit    = 0;
    int n_exhaust  = 0;
    int n_badid    = 0;

    size_class_buffer_pool DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_req_size      (s_req_size),
        .s_buffer_id     (s_buffer_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_status        (m_status),
        .m_granted_id    (m_granted_id),
        .m_granted_class (m_granted_class),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data)
    );

    pool_grant_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_req_size      (s_req_size),
        .s_buffer_id     (s_buffer_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_status        (m_status),
        .m_granted_id    (m_granted_id),
        .m_granted_class (m_granted_class),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .errors          (errors),
        .pending         (pending),
        .checked         (checked)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items outstanding", cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic cmd, input logic [SIZE_W-1:0] req,
                             input logic [ID_W-1:0] bid);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_req_size  <= req;
        s_buffer_id <= bid;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cmd_sent.push_back(cmd);
        if (cmd == CMD_ALLOC) n_alloc++;
        else n_free++;
        @(negedge aclk);
    endtask

    task automatic set_sizes(input logic [SIZE_W-1:0] v0, input logic [SIZE_W-1:0] v1,
                             input logic [SIZE_W-1:0] v2, input logic [SIZE_W-1:0] v3);
        logic [SIZE_W-1:0] v [NUM_CLASSES];
        v = '{v0, v1, v2, v3};
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge aclk);
        for (int i = 0; i < NUM_CLASSES; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= CFG_IDX_W'(i);
            cfg_wr_data <= v[i];
            sizes[i]     = v[i];
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [SIZE_W-1:0] pick_req();
        int                r;
        int                k;
        logic [SIZE_W-1:0] mx;
        r  = $urandom_range(99, 0);
        k  = $urandom_range(NUM_CLASSES - 1, 0);
        mx = sizes[0];
        for (int i = 1; i < NUM_CLASSES; i++) begin
            if (sizes[i] > mx) mx = sizes[i];
        end
        if (r < 6) return SIZE_W'($urandom_range(65535, mx));
        if (r < 10) return (r % 2) ? '1 : '0;
        if (r < 14) return SIZE_W'($urandom());
        if (r < 22) return (r % 2) ? sizes[k] : sizes[k] - 1'b1;
        return SIZE_W'($urandom_range(sizes[k] - 1, 0));
    endfunction

    task automatic random_op(input int alloc_pct);
        int              idx;
        logic [ID_W-1:0] bid;
        if ($urandom_range(99, 0) < alloc_pct) begin
            send_item(CMD_ALLOC, pick_req(), ID_W'($urandom()));
        end else begin
            if (held_ids.size() > 0 && $urandom_range(99, 0) < 92) begin
                idx = $urandom_range(held_ids.size() - 1, 0);
                bid = ID_W'(held_ids[idx]);
                held_ids.delete(idx);
            end else begin
                // stray id: double free or outside the pool
                bid = ID_W'($urandom_range(31, 0));
            end
            send_item(CMD_FREE, SIZE_W'($urandom()), bid);
        end
    endtask

    // result side
    initial begin
        int   gap;
        logic c;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(negedge aclk);
            end
            gap = $urandom_range(rx_gap_max, 0);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            c = cmd_sent.pop_front();
            if (c == CMD_ALLOC && m_ok) held_ids.push_back(m_granted_id);
            case (m_status)
                ST_NO_FIT:    n_nofit++;
                ST_EXHAUSTED: n_exhaust++;
                ST_BAD_ID:    n_badid++;
                default: ;
            endcase
            @(negedge aclk);
        end
    end

    initial begin
        logic [SIZE_W-1:0] v [NUM_CLASSES];
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset sizes 256/1024/4096/16384
        send_item(CMD_ALLOC, 16'd0, 5'd0);
        send_item(CMD_ALLOC, 16'd255, 5'd31);
        send_item(CMD_ALLOC, 16'd256, 5'd0);
        repeat (4) send_item(CMD_ALLOC, 16'd4000, 5'd0);
        send_item(CMD_ALLOC, 16'd4000, 5'd0);       // class 2 empty, falls to class 3
        send_item(CMD_ALLOC, 16'd16383, 5'd0);
        send_item(CMD_ALLOC, 16'd16383, 5'd0);      // pool exhausted
        send_item(CMD_ALLOC, 16'd16384, 5'd0);      // no class fits
        send_item(CMD_ALLOC, 16'hFFFF, 5'd0);
        send_item(CMD_FREE, 16'd0, 5'd30);          // bad id
        send_item(CMD_FREE, 16'hFFFF, 5'd31);
        send_item(CMD_FREE, 16'd0, 5'd28);
        send_item(CMD_FREE, 16'd0, 5'd0);
        send_item(CMD_FREE, 16'd0, 5'd0);           // double free
        send_item(CMD_FREE, 16'd0, 5'd29);
        send_item(CMD_ALLOC, 16'd0, 5'd0);
        send_item(CMD_ALLOC, 16'd0, 5'd0);          // same id again
        send_item(CMD_ALLOC, 16'd20000, 5'd0);
        send_item(CMD_FREE, 16'd0, 5'd16);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: v = '{16'd256, 16'd1024, 16'd4096, 16'd16384};
                1: v = '{16'd1, 16'd1, 16'd1, 16'd1};
                2: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                3: v = '{16'd40000, 16'd300, 16'hFFFF, 16'd1};   // unordered
                4: v = '{16'd100, 16'd200, 16'd300, 16'd400};
                6: v = '{16'hFFFF, 16'd1, 16'hFFFF, 16'd1};
                default: begin
                    for (int i = 0; i < NUM_CLASSES; i++) begin
                        v[i] = SIZE_W'($urandom_range(65535, 1));
                    end
                end
            endcase
            set_sizes(v[0], v[1], v[2], v[3]);
            case (p % 4)
                0: begin tx_gap_max = 9; rx_gap_max = 9; end
                1: begin tx_gap_max = 0; rx_gap_max = 0; end
                2: begin tx_gap_max = 9; rx_gap_max = 0; end
                default: begin tx_gap_max = 0; rx_gap_max = 9; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                random_op(((i / 40) % 2 == 0) ? 75 : 30);
                if (p == 2 && i == 100) begin
                    // output stalls for a long stretch while items keep coming
                    hold_pending = 1'b1;
                    tx_gap_max   = 0;
                    repeat (40) random_op(60);
                    tx_gap_max = 9;
                    s_valid <= 1'b0;
                    wait (pending == 0);
                    @(negedge aclk);
                end
            end
        end

        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge aclk);
        $display("%0d items (%0d alloc, %0d free) over %0d size settings, %0d results checked",
                 n_alloc + n_free, n_alloc, n_free, n_settings, checked);
        $display("no-fit %0d, exhausted %0d, bad id %0d, one long output stall",
                 n_nofit, n_exhaust, n_badid);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
